[hw/rtl/assert_macros.svh]
// Assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, masked while reset is asserted
`define RCS_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("rcs check failed");

// Next-cycle implication, masked while reset is asserted
`define RCS_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("rcs check failed");

`endif

[hw/rtl/rcs_pkg.sv]
// Types and constants shared by the stick command shaper
package rcs_pkg;

	localparam int CURVE_POINTS = 12;
	localparam int KNOTS = CURVE_POINTS - 1;
	localparam int KIDX_W = $clog2(KNOTS);
	localparam int YAW_DIRECTION_DEF = 1;

	// divider geometry: quotient bits, divisor bits, remainder bits
	localparam int QW = 10;
	localparam int DW = 11;
	localparam int RW = 22;

	localparam int QDEPTH = 4;
	localparam int QPTR_W = $clog2(QDEPTH);

	typedef enum logic [2:0] {
		REG_MID_RC     = 3'd0,
		REG_MIN_CHECK  = 3'd1,
		REG_RP_DB      = 3'd2,
		REG_YAW_DB     = 3'd3,
		REG_TPA_BP     = 3'd4,
		REG_TPA_MAX    = 3'd5,
		REG_THR_MID    = 3'd6,
		REG_THR_EXPO   = 3'd7
	} cfg_reg_t;

	typedef struct packed {
		logic [10:0] mid_rc;
		logic [10:0] min_check;
		logic [6:0]  rp_db;
		logic [6:0]  yaw_db;
		logic [10:0] tpa_bp;
		logic [6:0]  tpa_max;
		logic [6:0]  thr_mid;
		logic [6:0]  thr_expo;
	} cfg_t;

	// classified item handed from the front to the back
	typedef struct packed {
		logic signed [9:0] roll;
		logic signed [9:0] pitch;
		logic signed [9:0] yaw;
		logic [6:0]        tpa_sub;
		logic [RW-1:0]     tpa_num;
		logic [DW-1:0]     tpa_den;
		logic [RW-1:0]     sc_num;
		logic [DW-1:0]     sc_den;
	} job_t;

	// curve segment: knot value above 1000 and rise to the next knot
	typedef struct packed {
		logic [9:0] lo;
		logic [9:0] dl;
	} knot_t;

	typedef enum logic [2:0] {
		KN_SETUP,
		KN_SQUARE,
		KN_SCALE,
		KN_DIVIDE,
		KN_MIX,
		KN_STORE,
		KN_DONE
	} knot_state_t;

endpackage

[hw/rtl/rcs_front.sv]
// Front end: accepts a frame and turns it into axis commands and divider jobs
module rcs_front import rcs_pkg::*; #(
	parameter int YAW_DIRECTION = YAW_DIRECTION_DEF
) (
	input  cfg_t        cfg,
	input  logic        in_valid,
	input  logic [11:0] roll_in,
	input  logic [11:0] pitch_in,
	input  logic [11:0] yaw_in,
	input  logic [11:0] throttle_in,
	input  logic        knots_ready,
	input  logic        queue_full,
	output logic        in_ready,
	output logic        push,
	output job_t        job
);

	function automatic logic signed [9:0] axis_cmd(logic [11:0] p, logic [10:0] mid,
		logic [6:0] db);
		logic signed [12:0] d;
		logic [11:0]        a;
		logic [8:0]         m;
		logic signed [9:0]  c;
		d = $signed({1'b0, p}) - $signed({2'b00, mid});
		a = (d < 0) ? 12'(-d) : 12'(d);
		m = (a > 12'd500) ? 9'd500 : 9'(a);
		m = (m > {2'b00, db}) ? m - {2'b00, db} : 9'd0;
		c = $signed({1'b0, m});
		if (p < {1'b0, mid}) c = -c;
		return c;
	endfunction

	logic               below, above;
	logic [11:0]        tpa_diff;
	logic [11:0]        thr_c;
	logic signed [9:0]  yaw_raw;

	assign in_ready = knots_ready && !queue_full;
	assign push = in_valid && in_ready;

	always_comb begin
		job.roll = axis_cmd(roll_in, cfg.mid_rc, cfg.rp_db);
		job.pitch = axis_cmd(pitch_in, cfg.mid_rc, cfg.rp_db);
		yaw_raw = axis_cmd(yaw_in, cfg.mid_rc, cfg.yaw_db);
		if (YAW_DIRECTION > 0) begin
			job.yaw = -yaw_raw;
		end else if (YAW_DIRECTION == 0) begin
			job.yaw = '0;
		end else begin
			job.yaw = yaw_raw;
		end

		// attenuation: flat below the breakpoint, ramp up to 2000, fixed above
		below = throttle_in < {1'b0, cfg.tpa_bp};
		above = !below && (throttle_in >= 12'd2000);
		tpa_diff = 12'(throttle_in - {1'b0, cfg.tpa_bp});
		if (!below && !above) begin
			job.tpa_num = RW'(19'(cfg.tpa_max) * 19'(tpa_diff));
			job.tpa_den = DW'(12'd2000 - {1'b0, cfg.tpa_bp});
		end else begin
			job.tpa_num = '0;
			job.tpa_den = DW'(1);
		end
		job.tpa_sub = above ? cfg.tpa_max : 7'd0;

		// throttle scaling onto 0..1000
		if (throttle_in < {1'b0, cfg.min_check}) begin
			thr_c = {1'b0, cfg.min_check};
		end else if (throttle_in > 12'd2000) begin
			thr_c = 12'd2000;
		end else begin
			thr_c = throttle_in;
		end
		if (cfg.min_check >= 11'd2000) begin
			job.sc_num = '0;
			job.sc_den = DW'(1);
		end else begin
			job.sc_num = RW'(21'(thr_c - {1'b0, cfg.min_check}) * 21'd1000);
			job.sc_den = DW'(12'd2000 - {1'b0, cfg.min_check});
		end
	end

endmodule

[hw/rtl/rcs_queue.sv]
// Short queue of classified items between the front and the back
module rcs_queue import rcs_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  job_t wr_job,
	input  logic pop,
	output logic full,
	output logic empty,
	output job_t head
);

	job_t              mem_q [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [QPTR_W:0]   cnt_q;

	assign full = cnt_q == (QPTR_W+1)'(QDEPTH);
	assign empty = cnt_q == '0;
	assign head = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wr_ptr_q <= wr_ptr_q + 1'b1;
			if (pop) rd_ptr_q <= rd_ptr_q + 1'b1;
			if (push && !pop) cnt_q <= cnt_q + 1'b1;
			else if (pop && !push) cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_ptr_q] <= wr_job;
	end

endmodule

[hw/rtl/rcs_knots.sv]
// Throttle curve knot sequencer and segment table
module rcs_knots import rcs_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              restart,
	input  logic [6:0]        thr_mid,
	input  logic [6:0]        thr_expo,
	input  logic [KIDX_W-1:0] rd_idx,
	output knot_t             rd_ent,
	output logic              ready
);

	knot_state_t        state_q, state_d;
	logic [KIDX_W-1:0]  i_q;
	logic signed [8:0]  off_q;
	logic [6:0]         aoff_q, y_q, q_q;
	logic [13:0]        sq_q, den_q, p_q;
	logic [19:0]        r_q;
	logic [2:0]         bit_q;
	logic [9:0]         prev_q;
	knot_t              tab_q [KNOTS];

	logic [6:0]         mid_c, expo_c;
	logic signed [8:0]  off_c;
	logic [19:0]        dsub;
	logic [27:0]        mprod;
	logic [9:0]         tenmid, v;

	assign mid_c = (thr_mid > 7'd99) ? 7'd99 : thr_mid;
	assign expo_c = (thr_expo > 7'd100) ? 7'd100 : thr_expo;
	assign off_c = $signed(9'(i_q) * 9'd10) - $signed({2'b00, mid_c});
	assign dsub = 20'(den_q) << bit_q;
	assign mprod = 28'(p_q) * 28'd6554;
	assign tenmid = 10'(mid_c) * 10'd10;
	assign v = (off_q < 0) ? tenmid - mprod[25:16] : tenmid + mprod[25:16];
	assign rd_ent = tab_q[rd_idx];
	assign ready = state_q == KN_DONE;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= KN_SETUP;
			i_q <= '0;
			bit_q <= '0;
		end else begin
			state_q <= state_d;
			if (restart) begin
				i_q <= '0;
			end else if (state_q == KN_STORE) begin
				i_q <= i_q + 1'b1;
			end
			if (state_q == KN_SCALE) bit_q <= 3'd6;
			else if (state_q == KN_DIVIDE) bit_q <= bit_q - 1'b1;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			KN_SETUP:  state_d = KN_SQUARE;
			KN_SQUARE: state_d = KN_SCALE;
			KN_SCALE:  state_d = KN_DIVIDE;
			KN_DIVIDE: if (bit_q == '0) state_d = KN_MIX;
			KN_MIX:    state_d = KN_STORE;
			KN_STORE:  state_d = (i_q == KIDX_W'(KNOTS - 1)) ? KN_DONE : KN_SETUP;
			KN_DONE:   state_d = KN_DONE;
			default:   state_d = KN_SETUP;
		endcase
		if (restart) state_d = KN_SETUP;
	end

	always_ff @(posedge clk) begin
		case (state_q)
			KN_SETUP: begin
				off_q <= off_c;
				aoff_q <= (off_c < 0) ? 7'(-off_c) : 7'(off_c);
				if (off_c > 0) y_q <= 7'd100 - mid_c;
				else if (off_c < 0) y_q <= mid_c;
				else y_q <= 7'd1;
			end
			KN_SQUARE: begin
				sq_q <= 14'(aoff_q) * 14'(aoff_q);
				den_q <= 14'(y_q) * 14'(y_q);
			end
			KN_SCALE: begin
				r_q <= 20'(expo_c) * 20'(sq_q);
				q_q <= '0;
			end
			KN_DIVIDE: begin
				if (r_q >= dsub) begin
					r_q <= r_q - dsub;
					q_q[bit_q] <= 1'b1;
				end
			end
			KN_MIX: p_q <= 14'(aoff_q) * 14'(8'd100 - 8'(expo_c) + 8'(q_q));
			KN_STORE: begin
				tab_q[i_q].lo <= v;
				if (i_q != '0) tab_q[i_q - 1'b1].dl <= v - prev_q;
				if (i_q == KIDX_W'(KNOTS - 1)) tab_q[i_q].dl <= '0;
				prev_q <= v;
			end
			default: ;
		endcase
	end

endmodule

[hw/rtl/rcs_back.sv]
// Back end: pipelined dividers, curve interpolation and the output register
module rcs_back import rcs_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  job_t              job,
	input  logic              job_valid,
	output logic              pop,
	output logic [KIDX_W-1:0] kidx,
	input  knot_t             kent,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [47:0]       out_data
);

	typedef struct packed {
		logic signed [9:0] roll;
		logic signed [9:0] pitch;
		logic signed [9:0] yaw;
		logic [6:0]        tpa_sub;
		logic [DW-1:0]     tpa_den;
		logic [DW-1:0]     sc_den;
		logic [RW-1:0]     tpa_r;
		logic [QW-1:0]     tpa_q;
		logic [RW-1:0]     sc_r;
		logic [QW-1:0]     sc_q;
	} div_t;

	typedef struct packed {
		logic signed [9:0] roll;
		logic signed [9:0] pitch;
		logic signed [9:0] yaw;
		logic [6:0]        prop;
		logic [KIDX_W-1:0] idx;
		logic [6:0]        frac;
	} crv1_t;

	typedef struct packed {
		logic signed [9:0] roll;
		logic signed [9:0] pitch;
		logic signed [9:0] yaw;
		logic [6:0]        prop;
		logic [9:0]        lo;
		logic [16:0]       prod;
	} crv2_t;

	typedef struct packed {
		logic signed [9:0] roll;
		logic signed [9:0] pitch;
		logic signed [9:0] yaw;
		logic [10:0]       thr;
		logic [6:0]        prop;
	} crv3_t;

	localparam int NST = QW + 3;

	function automatic div_t div_advance(div_t x, int b);
		logic [RW-1:0] st, ss;
		st = RW'(x.tpa_den) << b;
		ss = RW'(x.sc_den) << b;
		if (x.tpa_r >= st) begin
			x.tpa_r = x.tpa_r - st;
			x.tpa_q[b] = 1'b1;
		end
		if (x.sc_r >= ss) begin
			x.sc_r = x.sc_r - ss;
			x.sc_q[b] = 1'b1;
		end
		return x;
	endfunction

	div_t          div_s [QW];
	div_t          div_d [QW];
	div_t          ld;
	crv1_t         crv_s1, crv1_d;
	crv2_t         crv_s2;
	crv3_t         crv_s3;
	logic [NST-1:0] vld_q;
	logic          en;
	logic [10:0]   qsum;
	logic [15:0]   idx_prod;
	logic [31:0]   rprod;

	// the whole pipe moves together unless the output item is stalled
	assign en = !vld_q[NST-1] || out_ready;
	assign pop = en && job_valid;
	assign kidx = crv_s1.idx;
	assign out_valid = vld_q[NST-1];
	assign out_data = {crv_s3.prop, crv_s3.thr, crv_s3.yaw, crv_s3.pitch, crv_s3.roll};

	always_comb begin
		ld.roll = job.roll;
		ld.pitch = job.pitch;
		ld.yaw = job.yaw;
		ld.tpa_sub = job.tpa_sub;
		ld.tpa_den = job.tpa_den;
		ld.sc_den = job.sc_den;
		ld.tpa_r = job.tpa_num;
		ld.tpa_q = '0;
		ld.sc_r = job.sc_num;
		ld.sc_q = '0;
		div_d[0] = div_advance(ld, QW - 1);
		for (int k = 1; k < QW; k++) begin
			div_d[k] = div_advance(div_s[k-1], QW - 1 - k);
		end

		qsum = 11'(div_s[QW-1].tpa_sub) + 11'(div_s[QW-1].tpa_q);
		idx_prod = 16'(div_s[QW-1].sc_q) * 16'd41;
		crv1_d.roll = div_s[QW-1].roll;
		crv1_d.pitch = div_s[QW-1].pitch;
		crv1_d.yaw = div_s[QW-1].yaw;
		crv1_d.prop = (qsum > 11'd100) ? 7'd0 : 7'(11'd100 - qsum);
		crv1_d.idx = idx_prod[15:12];
		crv1_d.frac = 7'(div_s[QW-1].sc_q - 10'(idx_prod[15:12]) * 10'd100);

		rprod = 32'(crv_s2.prod) * 32'd20972;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[NST-2:0], job_valid};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < QW; k++) div_s[k] <= div_d[k];
			crv_s1 <= crv1_d;
			crv_s2.roll <= crv_s1.roll;
			crv_s2.pitch <= crv_s1.pitch;
			crv_s2.yaw <= crv_s1.yaw;
			crv_s2.prop <= crv_s1.prop;
			crv_s2.lo <= kent.lo;
			crv_s2.prod <= 17'(crv_s1.frac) * 17'(kent.dl);
			crv_s3.roll <= crv_s2.roll;
			crv_s3.pitch <= crv_s2.pitch;
			crv_s3.yaw <= crv_s2.yaw;
			crv_s3.prop <= crv_s2.prop;
			crv_s3.thr <= 11'd1000 + 11'(crv_s2.lo) + 11'(rprod[31:21]);
		end
	end

endmodule

[hw/rtl/rc_stick_command_shaper.sv]
// Stick command shaper top level: registers, front, queue, curve table and back
// Accepted frames pass through the queue, then the divider and curve stages, to the output.
// Throughput: one item per cycle unless stalled, set by the pipelined ten-stage divider.
// After reset and after every configuration write, the knot sequencer rebuilds the
// curve table, one knot at a time for all 11 knots, with s_tready held low.
// Reset is asynchronous, active low, and loads the register defaults.
module rc_stick_command_shaper import rcs_pkg::*; #(
	parameter int YAW_DIRECTION = YAW_DIRECTION_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [47:0] s_tdata,   // roll_in, pitch_in, yaw_in, throttle_in
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [47:0] m_tdata,   // roll_cmd, pitch_cmd, yaw_cmd, throttle_cmd, pid_scale_percent
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [10:0] cfg_data
);

	cfg_t              cfg_q;
	logic              cfg_wr;
	logic              knots_ready, q_full, q_empty, push, pop;
	job_t              job, head;
	logic [KIDX_W-1:0] kidx;
	knot_t             kent;

	assign cfg_ready = 1'b1;
	assign cfg_wr = cfg_valid && cfg_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.mid_rc <= 11'd1500;
			cfg_q.min_check <= 11'd1100;
			cfg_q.rp_db <= 7'd0;
			cfg_q.yaw_db <= 7'd0;
			cfg_q.tpa_bp <= 11'd1500;
			cfg_q.tpa_max <= 7'd0;
			cfg_q.thr_mid <= 7'd50;
			cfg_q.thr_expo <= 7'd0;
		end else if (cfg_wr) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_MID_RC:    cfg_q.mid_rc <= cfg_data;
				REG_MIN_CHECK: cfg_q.min_check <= cfg_data;
				REG_RP_DB:     cfg_q.rp_db <= cfg_data[6:0];
				REG_YAW_DB:    cfg_q.yaw_db <= cfg_data[6:0];
				REG_TPA_BP:    cfg_q.tpa_bp <= cfg_data;
				REG_TPA_MAX:   cfg_q.tpa_max <= cfg_data[6:0];
				REG_THR_MID:   cfg_q.thr_mid <= cfg_data[6:0];
				REG_THR_EXPO:  cfg_q.thr_expo <= cfg_data[6:0];
				default: ;
			endcase
		end
	end

	rcs_front #(.YAW_DIRECTION(YAW_DIRECTION)) u_front (
		.cfg         (cfg_q),
		.in_valid    (s_tvalid),
		.roll_in     (s_tdata[11:0]),
		.pitch_in    (s_tdata[23:12]),
		.yaw_in      (s_tdata[35:24]),
		.throttle_in (s_tdata[47:36]),
		.knots_ready (knots_ready),
		.queue_full  (q_full),
		.in_ready    (s_tready),
		.push        (push),
		.job         (job)
	);

	rcs_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wr_job (job),
		.pop    (pop),
		.full   (q_full),
		.empty  (q_empty),
		.head   (head)
	);

	rcs_knots u_knots (
		.clk      (clk),
		.arst_n   (arst_n),
		.restart  (cfg_wr),
		.thr_mid  (cfg_q.thr_mid),
		.thr_expo (cfg_q.thr_expo),
		.rd_idx   (kidx),
		.rd_ent   (kent),
		.ready    (knots_ready)
	);

	rcs_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.job       (head),
		.job_valid (!q_empty),
		.pop       (pop),
		.kidx      (kidx),
		.kent      (kent),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_data  (m_tdata)
	);

endmodule

[hw/rtl/rcs_checker.sv]
// Port-level checks for the stick command shaper, bound to the top level
`include "assert_macros.svh"

module rcs_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [47:0] m_tdata,
	input logic        cfg_valid,
	input logic        cfg_ready
);

	// a register write rebuilds the curve, so input is held off next cycle
	`RCS_ASSERT_NEXT(a_cfg_blocks_input, cfg_valid && cfg_ready, !s_tready)
	`RCS_ASSERT_NOW(a_thr_range, m_tvalid, m_tdata[40:30] >= 11'd1000 && m_tdata[40:30] <= 11'd2000)
	`RCS_ASSERT_NOW(a_pid_range, m_tvalid, m_tdata[47:41] <= 7'd100)
	`RCS_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))

endmodule

bind rc_stick_command_shaper rcs_checker u_rcs_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.s_tready  (s_tready),
	.m_tvalid  (m_tvalid),
	.m_tready  (m_tready),
	.m_tdata   (m_tdata),
	.cfg_valid (cfg_valid),
	.cfg_ready (cfg_ready)
);

[tb/tb_rc_stick_command_shaper.sv]
// Self-checking shaper testbench: directed frames, then random frames per register setting
module tb_rc_stick_command_shaper;
	import rcs_pkg::*;

	typedef struct {
		logic signed [9:0] roll;
		logic signed [9:0] pitch;
		logic signed [9:0] yaw;
		logic [10:0]       thr;
		logic [6:0]        pid;
	} cmd_t;

	typedef struct {
		logic [11:0] roll;
		logic [11:0] pitch;
		logic [11:0] yaw;
		logic [11:0] thr;
		bit          typed;
		cmd_t        want;
	} frame_row_t;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [47:0] s_tdata;
	logic        m_tvalid;
	logic        m_tready;
	logic [47:0] m_tdata;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [2:0]  cfg_index;
	logic [10:0] cfg_data;

	// shadow of the register file, as written
	int mid_rc, min_check, rp_db, yaw_db, tpa_bp, tpa_max, thr_mid, thr_expo;

	cmd_t cmd_queue[$];
	int   errors;
	int   frames_sent;
	int   results_seen;
	int   phases_run;
	int   gap_mode;
	int   stall_mode;

	rc_stick_command_shaper u_top (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	initial clk = 1'b0;
	always #2 clk = ~clk;

	initial begin
		#2000000;
		$display("timeout: %0d results outstanding", cmd_queue.size());
		$display("TEST FAILED");
		$finish;
	end

	function automatic void shadow_write(cfg_reg_t idx, int value);
		case (idx)
			REG_MID_RC:    mid_rc = value & 'h7FF;
			REG_MIN_CHECK: min_check = value & 'h7FF;
			REG_RP_DB:     rp_db = value & 'h7F;
			REG_YAW_DB:    yaw_db = value & 'h7F;
			REG_TPA_BP:    tpa_bp = value & 'h7FF;
			REG_TPA_MAX:   tpa_max = value & 'h7F;
			REG_THR_MID:   thr_mid = value & 'h7F;
			REG_THR_EXPO:  thr_expo = value & 'h7F;
			default: ;
		endcase
	endfunction

	function automatic int axis_magnitude(int pulse, int db);
		int d;
		d = pulse - mid_rc;
		if (d < 0) d = -d;
		if (d > 500) d = 500;
		return (d > db) ? d - db : 0;
	endfunction

	function automatic int knot_value(int i);
		int m, e, off, y, v;
		m = (thr_mid > 99) ? 99 : thr_mid;
		e = (thr_expo > 100) ? 100 : thr_expo;
		off = 10 * i - m;
		y = 1;
		if (off > 0) y = 100 - m;
		if (off < 0) y = m;
		v = 10 * m + off * (100 - e + e * (off * off) / (y * y)) / 10;
		return 1000 + 1000 * v / 1000;
	endfunction

	function automatic cmd_t shape_frame(int roll, int pitch, int yaw, int thr);
		cmd_t r;
		int prop, c, scaled, idx, lo, hi, m;
		int pulse[3];
		int cmd[3];
		pulse[0] = roll;
		pulse[1] = pitch;
		pulse[2] = yaw;
		if (thr < tpa_bp) prop = 100;
		else if (thr < 2000) prop = 100 - tpa_max * (thr - tpa_bp) / (2000 - tpa_bp);
		else prop = 100 - tpa_max;
		if (prop < 0) prop = 0;
		for (int a = 0; a < 3; a++) begin
			if (a < 2) begin
				m = axis_magnitude(pulse[a], rp_db);
			end else begin
				m = axis_magnitude(pulse[a], yaw_db) * -(YAW_DIRECTION_DEF);
			end
			if (pulse[a] < mid_rc) m = -m;
			cmd[a] = m;
		end
		if (min_check >= 2000) begin
			scaled = 0;
		end else begin
			c = thr;
			if (c < min_check) c = min_check;
			if (c > 2000) c = 2000;
			scaled = (c - min_check) * 1000 / (2000 - min_check);
		end
		idx = scaled / 100;
		if (idx > CURVE_POINTS - 2) idx = CURVE_POINTS - 2;
		lo = knot_value(idx);
		hi = knot_value(idx + 1);
		r.roll = cmd[0][9:0];
		r.pitch = cmd[1][9:0];
		r.yaw = cmd[2][9:0];
		r.thr = 11'(lo + (scaled - idx * 100) * (hi - lo) / 100);
		r.pid = prop[6:0];
		return r;
	endfunction

	task automatic report_mismatch(string what, int got, int want);
		errors++;
		$display("mismatch at result %0d: %s got %0d expected %0d",
			results_seen, what, got, want);
	endtask

	always @(posedge clk) begin
		cmd_t w;
		if (arst_n && m_tvalid && m_tready) begin
			if (cmd_queue.size() == 0) begin
				errors++;
				$display("unexpected result: %h", m_tdata);
			end else begin
				w = cmd_queue.pop_front();
				if (m_tdata[9:0] !== w.roll) report_mismatch("roll", $signed(m_tdata[9:0]), w.roll);
				if (m_tdata[19:10] !== w.pitch)
					report_mismatch("pitch", $signed(m_tdata[19:10]), w.pitch);
				if (m_tdata[29:20] !== w.yaw) report_mismatch("yaw", $signed(m_tdata[29:20]), w.yaw);
				if (m_tdata[40:30] !== w.thr) report_mismatch("throttle", m_tdata[40:30], w.thr);
				if (m_tdata[47:41] !== w.pid) report_mismatch("pid scale", m_tdata[47:41], w.pid);
			end
			results_seen++;
		end
	end

	// receiver stalls: stall_mode 0 never stalls
	always @(posedge clk) begin
		int r;
		r = $urandom_range(0, 99);
		if (!arst_n || stall_mode == 0) m_tready <= 1'b1;
		else if (r < 4) m_tready <= 1'b0;
		else if (r < 25) m_tready <= ($urandom_range(0, 1) == 1);
		else if (r < 30 && stall_mode == 2) m_tready <= 1'b0;
		else m_tready <= 1'b1;
	end

	function automatic logic [11:0] random_pulse();
		int r;
		r = $urandom_range(0, 9);
		if (r == 0) return 12'($urandom);
		if (r == 1) begin
			case ($urandom_range(0, 4))
				0: return 12'd0;
				1: return 12'd4095;
				2: return 12'd1000;
				3: return 12'd2000;
				default: return 12'(mid_rc);
			endcase
		end
		return 12'($urandom_range(900, 2100));
	endfunction

	task automatic idle_gap();
		int r, n;
		r = $urandom_range(0, 99);
		n = 0;
		if (gap_mode != 0) begin
			if (r < 3) n = $urandom_range(10, 40);
			else if (r < 30) n = $urandom_range(1, 3);
		end
		if (n > 0) begin
			s_tvalid <= 1'b0;
			repeat (n) @(posedge clk);
		end
	endtask

	task automatic send_frame(logic [11:0] roll, logic [11:0] pitch, logic [11:0] yaw,
			logic [11:0] thr, bit typed, cmd_t want);
		s_tdata <= {thr, yaw, pitch, roll};
		s_tvalid <= 1'b1;
		do @(posedge clk); while (!s_tready);
		cmd_queue.push_back(typed ? want : shape_frame(roll, pitch, yaw, thr));
		frames_sent++;
		idle_gap();
	endtask

	// hold off until every result is back, then let the pipeline drain
	task automatic drain();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (cmd_queue.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	task automatic write_all(int v[8]);
		cfg_reg_t idx;
		for (int i = 0; i < 8; i++) begin
			idx = cfg_reg_t'(i);
			cfg_index <= idx;
			cfg_data <= 11'(v[i]);
			cfg_valid <= 1'b1;
			do @(posedge clk); while (!cfg_ready);
			shadow_write(idx, v[i]);
		end
		cfg_valid <= 1'b0;
	endtask

	task automatic random_frames(int n);
		cmd_t none;
		none = '{default: '0};
		for (int i = 0; i < n; i++)
			send_frame(random_pulse(), random_pulse(), random_pulse(), random_pulse(), 0, none);
	endtask

	frame_row_t directed[] = '{
		'{12'd1500, 12'd1500, 12'd1500, 12'd0,    1, '{10'sd0, 10'sd0, 10'sd0, 11'd1000, 7'd100}},
		'{12'd4095, 12'd4095, 12'd4095, 12'd4095, 1,
			'{10'sd500, 10'sd500, -10'sd500, 11'd2000, 7'd100}},
		'{12'd0,    12'd0,    12'd0,    12'd0,    1,
			'{-10'sd500, -10'sd500, 10'sd500, 11'd1000, 7'd100}},
		'{12'd2000, 12'd1000, 12'd1501, 12'd2000, 0, '{default: '0}},
		'{12'd1499, 12'd2001, 12'd999,  12'd1100, 0, '{default: '0}},
		'{12'd1000, 12'd2000, 12'd2000, 12'd1500, 0, '{default: '0}},
		'{12'd1750, 12'd1250, 12'd1234, 12'd1499, 0, '{default: '0}},
		'{12'd2048, 12'd2047, 12'd1024, 12'd1999, 0, '{default: '0}},
		'{12'd2730, 12'd1365, 12'd3003, 12'd1550, 0, '{default: '0}},
		'{12'd1500, 12'd1500, 12'd1500, 12'd1101, 0, '{default: '0}},
		'{12'd1500, 12'd1500, 12'd1500, 12'd1800, 0, '{default: '0}}
	};

	// mid_rc, min_check, rp_db, yaw_db, tpa_bp, tpa_max, thr_mid, thr_expo
	int settings[][8] = '{
		'{1200, 1000, 0,   100, 1000, 100, 0,   100},
		'{1800, 1999, 100, 0,   2000, 50,  99,  0},
		'{1500, 1100, 20,  30,  1400, 75,  30,  60},
		'{1500, 2000, 10,  10,  2047, 127, 127, 127},
		'{2047, 2047, 127, 127, 0,    101, 100, 101},
		'{0,    1500, 5,   50,  1700, 100, 70,  40},
		'{1520, 1050, 3,   8,   1300, 30,  45,  25}
	};

	initial begin
		int v[8];
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		m_tready = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = REG_MID_RC;
		cfg_data = '0;
		errors = 0;
		frames_sent = 0;
		results_seen = 0;
		phases_run = 0;
		gap_mode = 1;
		stall_mode = 1;
		mid_rc = 1500; min_check = 1100; rp_db = 0; yaw_db = 0;
		tpa_bp = 1500; tpa_max = 0; thr_mid = 50; thr_expo = 0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed[i])
			send_frame(directed[i].roll, directed[i].pitch, directed[i].yaw, directed[i].thr,
				directed[i].typed, directed[i].want);
		random_frames(60);
		phases_run++;

		foreach (settings[p]) begin
			drain();
			v = settings[p];
			write_all(v);
			gap_mode = p % 3;
			stall_mode = p % 3;
			random_frames(80);
			phases_run++;
		end
		for (int p = 0; p < 4; p++) begin
			drain();
			v[0] = $urandom_range(1200, 1800);
			v[1] = $urandom_range(1000, 1999);
			v[2] = $urandom_range(0, 100);
			v[3] = $urandom_range(0, 100);
			v[4] = $urandom_range(1000, 2000);
			v[5] = $urandom_range(0, 100);
			v[6] = $urandom_range(0, 99);
			v[7] = $urandom_range(0, 100);
			write_all(v);
			gap_mode = p % 2;
			stall_mode = (p + 1) % 3;
			random_frames(80);
			phases_run++;
		end

		drain();
		$display("sent %0d frames over %0d register settings, %0d results checked",
			frames_sent, phases_run, results_seen);
		if (errors == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("%0d mismatches", errors);
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule
